>>> rtl/core/ieas_pkg.sv
`default_nettype none
package ieas_pkg;

  localparam int unsigned IEAS_POLL_LIMIT = 10001;

  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned RETRY_W = 14;
  localparam int unsigned UPC_W   = 4;

  // command codes of an input word
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_RESP  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_TX   = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_WIDE  = 2'd1;
  localparam logic [1:0] REG_BLOCK = 2'd2;

  // access phase
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_WR_DATA = 3'd1;
  localparam logic [2:0] PH_WR_POLL = 3'd2;
  localparam logic [2:0] PH_RD_PTR  = 3'd3;
  localparam logic [2:0] PH_RD_DATA = 3'd4;

  // sequencing of the step counter
  localparam logic [1:0] SEQ_NEXT     = 2'd0;
  localparam logic [1:0] SEQ_JUMP     = 2'd1;
  localparam logic [1:0] SEQ_COND     = 2'd2;
  localparam logic [1:0] SEQ_DISPATCH = 2'd3;

  // jump conditions
  localparam logic [1:0] COND_ACK        = 2'd0;
  localparam logic [1:0] COND_NACK       = 2'd1;
  localparam logic [1:0] COND_DIV_BUSY   = 2'd2;
  localparam logic [1:0] COND_POLL_LIMIT = 2'd3;

  // result formats
  localparam logic [2:0] EMIT_NONE    = 3'd0;
  localparam logic [2:0] EMIT_REQ     = 3'd1;
  localparam logic [2:0] EMIT_POLL    = 3'd2;
  localparam logic [2:0] EMIT_RD_DATA = 3'd3;
  localparam logic [2:0] EMIT_FAIL    = 3'd4;
  localparam logic [2:0] EMIT_WR_OK   = 3'd5;
  localparam logic [2:0] EMIT_RD_OK   = 3'd6;
  localparam logic [2:0] EMIT_LIMIT   = 3'd7;

  localparam logic [1:0] DIV_NONE = 2'd0;
  localparam logic [1:0] DIV_INIT = 2'd1;
  localparam logic [1:0] DIV_STEP = 2'd2;

  localparam logic [1:0] POLL_KEEP  = 2'd0;
  localparam logic [1:0] POLL_CLEAR = 2'd1;
  localparam logic [1:0] POLL_INC   = 2'd2;
  localparam logic [1:0] POLL_LOAD  = 2'd3;

  localparam logic [2:0] PHOP_KEEP    = 3'd0;
  localparam logic [2:0] PHOP_IDLE    = 3'd1;
  localparam logic [2:0] PHOP_CMD     = 3'd2;
  localparam logic [2:0] PHOP_WR_POLL = 3'd3;
  localparam logic [2:0] PHOP_RD_DATA = 3'd4;

  // program steps
  localparam logic [UPC_W-1:0] ST_FETCH      = 4'd0;
  localparam logic [UPC_W-1:0] ST_DIV_INIT   = 4'd1;
  localparam logic [UPC_W-1:0] ST_DIV_STEP   = 4'd2;
  localparam logic [UPC_W-1:0] ST_REQ        = 4'd3;
  localparam logic [UPC_W-1:0] ST_WR_DATA    = 4'd4;
  localparam logic [UPC_W-1:0] ST_WR_DATA_OK = 4'd5;
  localparam logic [UPC_W-1:0] ST_POLL       = 4'd6;
  localparam logic [UPC_W-1:0] ST_POLL_CHK   = 4'd7;
  localparam logic [UPC_W-1:0] ST_POLL_AGAIN = 4'd8;
  localparam logic [UPC_W-1:0] ST_RD_PTR     = 4'd9;
  localparam logic [UPC_W-1:0] ST_RD_PTR_OK  = 4'd10;
  localparam logic [UPC_W-1:0] ST_RD_DATA    = 4'd11;
  localparam logic [UPC_W-1:0] ST_RD_OK      = 4'd12;
  localparam logic [UPC_W-1:0] ST_FAIL       = 4'd13;
  localparam logic [UPC_W-1:0] ST_WR_OK      = 4'd14;
  localparam logic [UPC_W-1:0] ST_LIMIT      = 4'd15;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] mem_address;
    logic [7:0]        write_value;
    logic              bus_ack;
    logic [7:0]        bus_rx_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         tx_byte0;
    logic [7:0]         tx_byte1;
    logic [7:0]         tx_byte2;
    logic [7:0]         tx_byte3;
    logic [2:0]         send_count;
    logic               receive_count;
    logic               fail;
    logic [7:0]         read_value;
    logic [RETRY_W-1:0] poll_retries;
  } out_t;

  typedef struct packed {
    logic [1:0]       seq;
    logic [1:0]       cond;
    logic [UPC_W-1:0] target;
    logic [2:0]       emit;
    logic [1:0]       div_op;
    logic [1:0]       poll_op;
    logic [2:0]       ph_op;
    logic             dev_load;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] step);
    ucode_t w;
    w = '0;
    case (step)
      ST_FETCH: begin
        w.seq = SEQ_DISPATCH;
      end
      ST_DIV_INIT: begin
        w.div_op = DIV_INIT;
      end
      ST_DIV_STEP: begin
        w.div_op = DIV_STEP;
        w.seq    = SEQ_COND;
        w.cond   = COND_DIV_BUSY;
        w.target = ST_DIV_STEP;
      end
      ST_REQ: begin
        w.emit     = EMIT_REQ;
        w.dev_load = 1'b1;
        w.poll_op  = POLL_CLEAR;
        w.ph_op    = PHOP_CMD;
        w.seq      = SEQ_JUMP;
        w.target   = ST_FETCH;
      end
      ST_WR_DATA: begin
        w.seq    = SEQ_COND;
        w.cond   = COND_NACK;
        w.target = ST_FAIL;
      end
      ST_WR_DATA_OK: begin
        w.emit    = EMIT_POLL;
        w.poll_op = POLL_CLEAR;
        w.ph_op   = PHOP_WR_POLL;
        w.seq     = SEQ_JUMP;
        w.target  = ST_FETCH;
      end
      ST_POLL: begin
        w.seq    = SEQ_COND;
        w.cond   = COND_ACK;
        w.target = ST_WR_OK;
      end
      ST_POLL_CHK: begin
        w.seq    = SEQ_COND;
        w.cond   = COND_POLL_LIMIT;
        w.target = ST_LIMIT;
      end
      ST_POLL_AGAIN: begin
        w.emit    = EMIT_POLL;
        w.poll_op = POLL_INC;
        w.seq     = SEQ_JUMP;
        w.target  = ST_FETCH;
      end
      ST_RD_PTR: begin
        w.seq    = SEQ_COND;
        w.cond   = COND_NACK;
        w.target = ST_FAIL;
      end
      ST_RD_PTR_OK: begin
        w.emit   = EMIT_RD_DATA;
        w.ph_op  = PHOP_RD_DATA;
        w.seq    = SEQ_JUMP;
        w.target = ST_FETCH;
      end
      ST_RD_DATA: begin
        w.seq    = SEQ_COND;
        w.cond   = COND_NACK;
        w.target = ST_FAIL;
      end
      ST_RD_OK: begin
        w.emit   = EMIT_RD_OK;
        w.ph_op  = PHOP_IDLE;
        w.seq    = SEQ_JUMP;
        w.target = ST_FETCH;
      end
      ST_FAIL: begin
        w.emit   = EMIT_FAIL;
        w.ph_op  = PHOP_IDLE;
        w.seq    = SEQ_JUMP;
        w.target = ST_FETCH;
      end
      ST_WR_OK: begin
        w.emit   = EMIT_WR_OK;
        w.ph_op  = PHOP_IDLE;
        w.seq    = SEQ_JUMP;
        w.target = ST_FETCH;
      end
      ST_LIMIT: begin
        w.emit    = EMIT_LIMIT;
        w.poll_op = POLL_LOAD;
        w.ph_op   = PHOP_IDLE;
        w.seq     = SEQ_JUMP;
        w.target  = ST_FETCH;
      end
      default: begin
        w.seq    = SEQ_JUMP;
        w.target = ST_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/i2c_eeprom_access_sequencer_core.sv
`default_nettype none
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    in_data   (ieas_pkg::in_t)
// out       output     out_valid / out_ready  out_data  (ieas_pkg::out_t)
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a request word runs through fetch, divider load, 16 divider steps
// (the address / block size split, one quotient bit a cycle) and the emit step.
// a response runs fetch, check steps and a result step; ignored words stay in fetch.
// reset is synchronous; it restores the config and control registers and returns to fetch.
// an emit step holds while the output register is still full; cfg_ready is always high.
module i2c_eeprom_access_sequencer_core
  import ieas_pkg::*;
#(
  parameter int unsigned POLL_LIMIT = IEAS_POLL_LIMIT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire in_t              in_data,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      out_t             out_data,
  input  wire logic             cfg_valid,
  output      logic             cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam logic [RETRY_W-1:0] LIMIT = RETRY_W'(POLL_LIMIT);
  localparam int unsigned DIV_CNT_W = $clog2(ADDR_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(ADDR_W - 1);

  logic [7:0]          base_address;
  logic                wide_addressing;
  logic [CFG_W-1:0]    block_size;

  logic [UPC_W-1:0]    upc;
  logic [UPC_W-1:0]    upc_next;
  logic [UPC_W-1:0]    dispatch;
  logic [2:0]          phase;
  logic [7:0]          device_byte;
  logic [RETRY_W-1:0]  poll_counter;

  logic [1:0]          cmd_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [7:0]          wdata_r;
  logic                ack_r;
  logic [7:0]          rx_r;

  logic [ADDR_W-1:0]   quo;
  logic [ADDR_W-1:0]   rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [ADDR_W:0]     divisor;
  logic [ADDR_W:0]     rem_sh;
  logic                sub_ok;

  ucode_t              uw;
  logic                stall;
  logic                go;
  logic                cond_true;
  logic                in_accept;
  logic [7:0]          dev_new;
  out_t                emit_word;

  assign uw        = ucode_rom(upc);
  assign in_ready  = (uw.seq == SEQ_DISPATCH);
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign stall     = (uw.emit != EMIT_NONE) && out_valid;
  assign go        = !stall;

  // block size zero stands for 65536
  assign divisor = (block_size == '0) ? {1'b1, {ADDR_W{1'b0}}} : {1'b0, block_size};
  assign rem_sh  = {rem, quo[ADDR_W-1]};
  assign sub_ok  = (rem_sh >= divisor);
  assign dev_new = base_address + {quo[6:0], 1'b0};

  always_comb begin
    case (uw.cond)
      COND_ACK:        cond_true = ack_r;
      COND_NACK:       cond_true = !ack_r;
      COND_DIV_BUSY:   cond_true = (div_cnt != DIV_LAST);
      COND_POLL_LIMIT: cond_true = (poll_counter >= LIMIT);
      default:         cond_true = 1'b0;
    endcase
  end

  always_comb begin
    dispatch = ST_FETCH;
    case (in_data.cmd)
      CMD_WRITE, CMD_READ: begin
        if (phase == PH_IDLE) dispatch = ST_DIV_INIT;
      end
      CMD_RESP: begin
        case (phase)
          PH_WR_DATA: dispatch = ST_WR_DATA;
          PH_WR_POLL: dispatch = ST_POLL;
          PH_RD_PTR:  dispatch = ST_RD_PTR;
          PH_RD_DATA: dispatch = ST_RD_DATA;
          default:    dispatch = ST_FETCH;
        endcase
      end
      default: dispatch = ST_FETCH;
    endcase
  end

  always_comb begin
    upc_next = upc;
    if (go) begin
      case (uw.seq)
        SEQ_NEXT:     upc_next = upc + 1'b1;
        SEQ_JUMP:     upc_next = uw.target;
        SEQ_COND:     upc_next = cond_true ? uw.target : upc + 1'b1;
        SEQ_DISPATCH: upc_next = in_accept ? dispatch : upc;
        default:      upc_next = ST_FETCH;
      endcase
    end
  end

  always_comb begin
    emit_word = '0;
    case (uw.emit)
      EMIT_REQ: begin
        emit_word.kind     = KIND_TX;
        emit_word.tx_byte0 = dev_new;
        if (cmd_r == CMD_WRITE) begin
          if (wide_addressing) begin
            emit_word.tx_byte1   = rem[15:8];
            emit_word.tx_byte2   = rem[7:0];
            emit_word.tx_byte3   = wdata_r;
            emit_word.send_count = 3'd4;
          end else begin
            emit_word.tx_byte1   = rem[7:0];
            emit_word.tx_byte2   = wdata_r;
            emit_word.send_count = 3'd3;
          end
        end else begin
          if (wide_addressing) begin
            emit_word.tx_byte1   = rem[15:8];
            emit_word.tx_byte2   = rem[7:0];
            emit_word.send_count = 3'd3;
          end else begin
            emit_word.tx_byte1   = rem[7:0];
            emit_word.send_count = 3'd2;
          end
        end
      end
      EMIT_POLL: begin
        emit_word.kind       = KIND_TX;
        emit_word.tx_byte0   = device_byte;
        emit_word.send_count = 3'd1;
      end
      EMIT_RD_DATA: begin
        emit_word.kind          = KIND_TX;
        emit_word.tx_byte0      = device_byte | 8'h01;
        emit_word.send_count    = 3'd1;
        emit_word.receive_count = 1'b1;
      end
      EMIT_FAIL: begin
        emit_word.kind = KIND_DONE;
        emit_word.fail = 1'b1;
      end
      EMIT_WR_OK: begin
        emit_word.kind         = KIND_DONE;
        emit_word.poll_retries = poll_counter;
      end
      EMIT_RD_OK: begin
        emit_word.kind       = KIND_DONE;
        emit_word.read_value = rx_r;
      end
      EMIT_LIMIT: begin
        emit_word.kind         = KIND_DONE;
        emit_word.fail         = 1'b1;
        emit_word.poll_retries = LIMIT;
      end
      default: emit_word = '0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address    <= 8'hA0;
      wide_addressing <= 1'b0;
      block_size      <= CFG_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASE:  base_address    <= cfg_data[7:0];
        REG_WIDE:  wide_addressing <= cfg_data[0];
        REG_BLOCK: block_size      <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer control state
  always_ff @(posedge clk) begin
    if (rst) begin
      upc          <= ST_FETCH;
      phase        <= PH_IDLE;
      device_byte  <= '0;
      poll_counter <= '0;
      out_valid    <= 1'b0;
    end else begin
      upc <= upc_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (go) begin
        if (uw.emit != EMIT_NONE) out_valid <= 1'b1;
        if (uw.dev_load) device_byte <= dev_new;
        case (uw.poll_op)
          POLL_CLEAR: poll_counter <= '0;
          POLL_INC:   poll_counter <= poll_counter + 1'b1;
          POLL_LOAD:  poll_counter <= LIMIT;
          default: ;
        endcase
        case (uw.ph_op)
          PHOP_IDLE:    phase <= PH_IDLE;
          PHOP_CMD:     phase <= (cmd_r == CMD_WRITE) ? PH_WR_DATA : PH_RD_PTR;
          PHOP_WR_POLL: phase <= PH_WR_POLL;
          PHOP_RD_DATA: phase <= PH_RD_DATA;
          default: ;
        endcase
      end
    end
  end

  // datapath: latched word, divider, output register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r   <= in_data.cmd;
      addr_r  <= in_data.mem_address;
      wdata_r <= in_data.write_value;
      ack_r   <= in_data.bus_ack;
      rx_r    <= in_data.bus_rx_byte;
    end
    case (uw.div_op)
      DIV_INIT: begin
        quo     <= addr_r;
        rem     <= '0;
        div_cnt <= '0;
      end
      DIV_STEP: begin
        // restoring division, one quotient bit a cycle
        quo     <= {quo[ADDR_W-2:0], sub_ok};
        rem     <= sub_ok ? ADDR_W'(rem_sh - divisor) : rem_sh[ADDR_W-1:0];
        div_cnt <= div_cnt + 1'b1;
      end
      default: ;
    endcase
    if (go && (uw.emit != EMIT_NONE)) out_data <= emit_word;
  end

endmodule
`default_nettype wire
